FILE: sv/tss_pkg.sv
// Package for the 2-SAT solver: the clause request type, the sequencer states
// and the fixed field widths. It depends on nothing else.
`timescale 1ns / 1ps

package tss_pkg;

    localparam int VAR_W   = 5;
    localparam int COMP_W  = 6;
    localparam int VCNT_W  = 6;
    localparam int ASG_W   = 32;

    typedef struct packed {
        logic             drop;
        logic             last;
        logic [VAR_W-1:0] a;
        logic             an;
        logic [VAR_W-1:0] b;
        logic             bn;
    } clause_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WR2,
        S_PREP,
        S_BLD_RD,
        S_BLD_CHK,
        S_F_ROOT,
        S_F_SCAN,
        S_F_CHK,
        S_F_POP,
        S_F_POPW,
        S_R_ROOT,
        S_R_ROOTW,
        S_R_SCAN,
        S_R_IDX,
        S_R_CHK,
        S_R_POP,
        S_R_POPW,
        S_EVAL,
        S_E_RDF,
        S_E_CMP
    } state_t;

endpackage

FILE: sv/tss_ram.sv
// Generic single write port, single read port RAM with registered read data.
// It depends on nothing else.
`timescale 1ns / 1ps

module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/tss_front.sv
// Front end of the 2-SAT solver: takes clause requests, flags out-of-range
// variables and holds them in a two-entry queue. Depends on tss_pkg.
`timescale 1ns / 1ps

module tss_front #(
    parameter int NUM_VARS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [tss_pkg::VAR_W-1:0] first_var,
    input  logic                      first_negated,
    input  logic [tss_pkg::VAR_W-1:0] second_var,
    input  logic                      second_negated,
    input  logic                      last_clause,
    input  logic                      done,
    output logic                      q_valid,
    output tss_pkg::clause_t          q_item,
    input  logic                      q_pop
);

    tss_pkg::clause_t entry_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pending_reg, pending_next;
    logic             accept;
    tss_pkg::clause_t item;

    assign busy    = (count_reg == 2'd2) || pending_reg;
    assign accept  = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rptr_reg];

    always_comb
    begin
        item.drop = (int'(first_var) >= NUM_VARS) || (int'(second_var) >= NUM_VARS);
        item.last = last_clause;
        item.a    = first_var;
        item.an   = first_negated;
        item.b    = second_var;
        item.bn   = second_negated;
    end

    always_comb
    begin
        wptr_next    = accept ? ~wptr_reg : wptr_reg;
        rptr_next    = q_pop ? ~rptr_reg : rptr_reg;
        count_next   = count_reg + 2'(accept) - 2'(q_pop);
        pending_next = pending_reg;
        if (done)
        begin
            pending_next = 1'b0;
        end
        if (accept && last_clause)
        begin
            pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg    <= 1'b0;
            rptr_reg    <= 1'b0;
            count_reg   <= 2'd0;
            pending_reg <= 1'b0;
        end
        else
        begin
            wptr_reg    <= wptr_next;
            rptr_reg    <= rptr_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wptr_reg] <= item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_clause) |=> busy)
        else $error("not busy after final clause");

endmodule

FILE: sv/tss_back.sv
// Back end of the 2-SAT solver: stores implication edges and runs the two
// depth-first passes and the assignment. Depends on tss_pkg and tss_ram.
`timescale 1ns / 1ps

module tss_back #(
    parameter int NUM_VARS    = 32,
    parameter int MAX_CLAUSES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  tss_pkg::clause_t           q_item,
    output logic                       q_pop,
    output logic                       done,
    output logic                       satisfiable,
    output logic [tss_pkg::VCNT_W-1:0] var_count,
    output logic [tss_pkg::ASG_W-1:0]  assignment,
    output logic                       overflow
);

    localparam int NODE_CAP = 2 * NUM_VARS;
    localparam int EDGE_CAP = 2 * MAX_CLAUSES;
    localparam int NA = $clog2(NODE_CAP);
    localparam int NW = $clog2(NODE_CAP + 1);
    localparam int EA = $clog2(EDGE_CAP);
    localparam int EW = $clog2(EDGE_CAP + 1);
    localparam int XW = $clog2(NUM_VARS + 1);
    localparam int CW = tss_pkg::COMP_W;

    tss_pkg::state_t state_reg, state_next;

    logic [EW-1:0]       cnt_reg, cnt_next;
    logic [NW-1:0]       nlim_reg, nlim_next;
    logic                lost_reg, lost_next;
    logic                last_reg, last_next;
    logic [2*NA-1:0]     sec_reg, sec_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [NODE_CAP-1:0] vis1_reg, vis1_next;
    logic [NODE_CAP-1:0] vis2_reg, vis2_next;
    logic [NW-1:0]       sp_reg, sp_next;
    logic [NA-1:0]       top_reg, top_next;
    logic [EW-1:0]       cur_reg, cur_next;
    logic [NW-1:0]       fc_reg, fc_next;
    logic [NW-1:0]       s_reg, s_next;
    logic [EW-1:0]       e_reg, e_next;
    logic [EW-1:0]       r_reg, r_next;
    logic [CW-1:0]       comp_reg, comp_next;
    logic [XW-1:0]       x_reg, x_next;
    logic [CW-1:0]       ct_reg, ct_next;
    logic                sat_reg, sat_next;
    logic [tss_pkg::ASG_W-1:0] asg_reg, asg_next;
    logic                done_reg, done_next;
    logic                osat_reg, osat_next;
    logic [tss_pkg::VCNT_W-1:0] ovc_reg, ovc_next;
    logic [tss_pkg::ASG_W-1:0]  oasg_reg, oasg_next;
    logic                oovf_reg, oovf_next;

    logic          ed_we;
    logic [EA-1:0] ed_raddr;
    logic [2*NA-1:0] ed_wdata, ed_rdata;
    logic          rv_we;
    logic [EA-1:0] rv_rdata;
    logic          st_we;
    logic [NA-1:0] st_waddr, st_raddr;
    logic [NA+EW-1:0] st_wdata, st_rdata;
    logic          fl_we;
    logic [NA-1:0] fl_rdata;
    logic          cm_we;
    logic [NA-1:0] cm_waddr, cm_raddr;
    logic [CW-1:0] cm_rdata;

    logic [NA-1:0] e_src, e_tgt;
    logic          cap_full, q_ok, cur_end, sp_one, f_hit, r_hit, e_mine, eval_end;
    logic [NW-1:0] top_new;
    logic [NA-1:0] src1, tgt1, src2, tgt2;
    logic [tss_pkg::VAR_W-1:0] vmax;

    assign e_src    = ed_rdata[2*NA-1:NA];
    assign e_tgt    = ed_rdata[NA-1:0];
    assign cap_full = ({1'b0, cnt_reg} + (EW+1)'(2)) > (EW+1)'(EDGE_CAP);
    assign q_ok     = !q_item.drop && !cap_full;
    assign cur_end  = cur_reg >= cnt_reg;
    assign sp_one   = sp_reg == NW'(1);
    assign f_hit    = (e_src == top_reg) && (NW'(e_tgt) < n_reg) && !vis1_reg[e_tgt];
    assign r_hit    = (e_tgt == top_reg) && !vis2_reg[e_src];
    assign e_mine   = NW'(e_src) == s_reg;
    assign eval_end = ((NW+1)'({x_reg, 1'b0}) + (NW+1)'(1)) >= (NW+1)'(n_reg);
    assign vmax     = (q_item.a > q_item.b) ? q_item.a : q_item.b;
    assign top_new  = (NW'(vmax) << 1) + NW'(2);
    assign src1 = NA'((NW'(q_item.a) << 1) | NW'(!q_item.an));
    assign tgt1 = NA'((NW'(q_item.b) << 1) | NW'(q_item.bn));
    assign src2 = NA'((NW'(q_item.b) << 1) | NW'(!q_item.bn));
    assign tgt2 = NA'((NW'(q_item.a) << 1) | NW'(q_item.an));

    assign done        = done_reg;
    assign satisfiable = osat_reg;
    assign var_count   = ovc_reg;
    assign assignment  = oasg_reg;
    assign overflow    = oovf_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tss_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_ok)
                        state_next = tss_pkg::S_WR2;
                    else if (q_item.last)
                        state_next = tss_pkg::S_PREP;
                end
            end
            tss_pkg::S_WR2:
                state_next = last_reg ? tss_pkg::S_PREP : tss_pkg::S_IDLE;
            tss_pkg::S_PREP:
                state_next = tss_pkg::S_BLD_RD;
            tss_pkg::S_BLD_RD:
            begin
                if (s_reg >= n_reg)
                    state_next = tss_pkg::S_F_ROOT;
                else if (e_reg < cnt_reg)
                    state_next = tss_pkg::S_BLD_CHK;
            end
            tss_pkg::S_BLD_CHK:
                state_next = tss_pkg::S_BLD_RD;
            tss_pkg::S_F_ROOT:
            begin
                if (s_reg >= n_reg)
                    state_next = tss_pkg::S_R_ROOT;
                else if (!vis1_reg[NA'(s_reg)])
                    state_next = tss_pkg::S_F_SCAN;
            end
            tss_pkg::S_F_SCAN:
                state_next = cur_end ? tss_pkg::S_F_POP : tss_pkg::S_F_CHK;
            tss_pkg::S_F_CHK:
                state_next = tss_pkg::S_F_SCAN;
            tss_pkg::S_F_POP:
                state_next = sp_one ? tss_pkg::S_F_ROOT : tss_pkg::S_F_POPW;
            tss_pkg::S_F_POPW:
                state_next = tss_pkg::S_F_SCAN;
            tss_pkg::S_R_ROOT:
                state_next = (fc_reg == '0) ? tss_pkg::S_EVAL : tss_pkg::S_R_ROOTW;
            tss_pkg::S_R_ROOTW:
                state_next = vis2_reg[fl_rdata] ? tss_pkg::S_R_ROOT : tss_pkg::S_R_SCAN;
            tss_pkg::S_R_SCAN:
                state_next = cur_end ? tss_pkg::S_R_POP : tss_pkg::S_R_IDX;
            tss_pkg::S_R_IDX:
                state_next = tss_pkg::S_R_CHK;
            tss_pkg::S_R_CHK:
                state_next = tss_pkg::S_R_SCAN;
            tss_pkg::S_R_POP:
                state_next = sp_one ? tss_pkg::S_R_ROOT : tss_pkg::S_R_POPW;
            tss_pkg::S_R_POPW:
                state_next = tss_pkg::S_R_SCAN;
            tss_pkg::S_EVAL:
                state_next = eval_end ? tss_pkg::S_IDLE : tss_pkg::S_E_RDF;
            tss_pkg::S_E_RDF:
                state_next = tss_pkg::S_E_CMP;
            tss_pkg::S_E_CMP:
                state_next = tss_pkg::S_EVAL;
            default:
                state_next = tss_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        nlim_next = nlim_reg;
        lost_next = lost_reg;
        last_next = last_reg;
        sec_next  = sec_reg;
        n_next    = n_reg;
        vis1_next = vis1_reg;
        vis2_next = vis2_reg;
        sp_next   = sp_reg;
        top_next  = top_reg;
        cur_next  = cur_reg;
        fc_next   = fc_reg;
        s_next    = s_reg;
        e_next    = e_reg;
        r_next    = r_reg;
        comp_next = comp_reg;
        x_next    = x_reg;
        ct_next   = ct_reg;
        sat_next  = sat_reg;
        asg_next  = asg_reg;
        done_next = 1'b0;
        osat_next = osat_reg;
        ovc_next  = ovc_reg;
        oasg_next = oasg_reg;
        oovf_next = oovf_reg;
        q_pop     = 1'b0;
        ed_we     = 1'b0;
        ed_wdata  = sec_reg;
        ed_raddr  = EA'(cur_reg);
        rv_we     = 1'b0;
        st_we     = 1'b0;
        st_waddr  = NA'(sp_reg - NW'(1));
        st_wdata  = {top_reg, cur_reg + EW'(1)};
        st_raddr  = NA'(sp_reg - NW'(2));
        fl_we     = 1'b0;
        cm_we     = 1'b0;
        cm_waddr  = e_src;
        cm_raddr  = NA'({x_reg, 1'b0});
        case (state_reg)
            tss_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    last_next = q_item.last;
                    if (q_ok)
                    begin
                        ed_we    = 1'b1;
                        ed_wdata = {src1, tgt1};
                        sec_next = {src2, tgt2};
                        cnt_next = cnt_reg + EW'(1);
                        if (top_new > nlim_reg)
                            nlim_next = top_new;
                    end
                    else
                    begin
                        lost_next = 1'b1;
                    end
                end
            end
            tss_pkg::S_WR2:
            begin
                ed_we    = 1'b1;
                cnt_next = cnt_reg + EW'(1);
            end
            tss_pkg::S_PREP:
            begin
                n_next    = nlim_reg;
                vis1_next = '0;
                vis2_next = '0;
                s_next    = '0;
                e_next    = '0;
                r_next    = '0;
                fc_next   = '0;
                comp_next = '0;
                x_next    = '0;
                sat_next  = 1'b1;
                asg_next  = '0;
            end
            tss_pkg::S_BLD_RD:
            begin
                ed_raddr = EA'(e_reg);
                if (s_reg >= n_reg)
                begin
                    s_next = '0;
                end
                else if (e_reg >= cnt_reg)
                begin
                    s_next = s_reg + NW'(1);
                    e_next = '0;
                end
            end
            tss_pkg::S_BLD_CHK:
            begin
                if (e_mine)
                begin
                    rv_we  = 1'b1;
                    r_next = r_reg + EW'(1);
                end
                e_next = e_reg + EW'(1);
            end
            tss_pkg::S_F_ROOT:
            begin
                if (s_reg < n_reg)
                begin
                    if (vis1_reg[NA'(s_reg)])
                    begin
                        s_next = s_reg + NW'(1);
                    end
                    else
                    begin
                        vis1_next[NA'(s_reg)] = 1'b1;
                        top_next = NA'(s_reg);
                        cur_next = '0;
                        sp_next  = NW'(1);
                    end
                end
            end
            tss_pkg::S_F_SCAN:
            begin
                if (cur_end)
                begin
                    fl_we   = 1'b1;
                    fc_next = fc_reg + NW'(1);
                end
            end
            tss_pkg::S_F_CHK:
            begin
                if (f_hit)
                begin
                    st_we           = 1'b1;
                    vis1_next[e_tgt] = 1'b1;
                    top_next        = e_tgt;
                    cur_next        = '0;
                    sp_next         = sp_reg + NW'(1);
                end
                else
                begin
                    cur_next = cur_reg + EW'(1);
                end
            end
            tss_pkg::S_F_POP, tss_pkg::S_R_POP:
            begin
                sp_next = sp_reg - NW'(1);
                if (sp_one && state_reg == tss_pkg::S_R_POP)
                    comp_next = comp_reg + CW'(1);
            end
            tss_pkg::S_F_POPW, tss_pkg::S_R_POPW:
            begin
                top_next = st_rdata[NA+EW-1:EW];
                cur_next = st_rdata[EW-1:0];
            end
            tss_pkg::S_R_ROOTW:
            begin
                fc_next  = fc_reg - NW'(1);
                cm_waddr = fl_rdata;
                if (!vis2_reg[fl_rdata])
                begin
                    vis2_next[fl_rdata] = 1'b1;
                    cm_we    = 1'b1;
                    top_next = fl_rdata;
                    cur_next = '0;
                    sp_next  = NW'(1);
                end
            end
            tss_pkg::S_R_IDX:
            begin
                ed_raddr = rv_rdata;
            end
            tss_pkg::S_R_CHK:
            begin
                if (r_hit)
                begin
                    st_we            = 1'b1;
                    vis2_next[e_src] = 1'b1;
                    cm_we            = 1'b1;
                    top_next         = e_src;
                    cur_next         = '0;
                    sp_next          = sp_reg + NW'(1);
                end
                else
                begin
                    cur_next = cur_reg + EW'(1);
                end
            end
            tss_pkg::S_EVAL:
            begin
                if (eval_end)
                begin
                    done_next = 1'b1;
                    osat_next = sat_reg;
                    ovc_next  = tss_pkg::VCNT_W'(n_reg >> 1);
                    oasg_next = sat_reg ? asg_reg : '0;
                    oovf_next = lost_reg;
                    cnt_next  = '0;
                    nlim_next = '0;
                    lost_next = 1'b0;
                end
            end
            tss_pkg::S_E_RDF:
            begin
                ct_next  = cm_rdata;
                cm_raddr = NA'({x_reg, 1'b1});
            end
            tss_pkg::S_E_CMP:
            begin
                if (ct_reg == cm_rdata)
                    sat_next = 1'b0;
                else if (ct_reg > cm_rdata && int'(x_reg) < tss_pkg::ASG_W)
                    asg_next[5'(x_reg)] = 1'b1;
                x_next = x_reg + XW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tss_pkg::S_IDLE;
            cnt_reg   <= '0;
            nlim_reg  <= '0;
            lost_reg  <= 1'b0;
            last_reg  <= 1'b0;
            n_reg     <= '0;
            vis1_reg  <= '0;
            vis2_reg  <= '0;
            sp_reg    <= '0;
            fc_reg    <= '0;
            s_reg     <= '0;
            e_reg     <= '0;
            r_reg     <= '0;
            comp_reg  <= '0;
            x_reg     <= '0;
            sat_reg   <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            nlim_reg  <= nlim_next;
            lost_reg  <= lost_next;
            last_reg  <= last_next;
            n_reg     <= n_next;
            vis1_reg  <= vis1_next;
            vis2_reg  <= vis2_next;
            sp_reg    <= sp_next;
            fc_reg    <= fc_next;
            s_reg     <= s_next;
            e_reg     <= e_next;
            r_reg     <= r_next;
            comp_reg  <= comp_next;
            x_reg     <= x_next;
            sat_reg   <= sat_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg  <= sec_next;
        top_reg  <= top_next;
        cur_reg  <= cur_next;
        ct_reg   <= ct_next;
        asg_reg  <= asg_next;
        osat_reg <= osat_next;
        ovc_reg  <= ovc_next;
        oasg_reg <= oasg_next;
        oovf_reg <= oovf_next;
    end

    tss_ram #(.WIDTH(2 * NA), .DEPTH(EDGE_CAP)) u_edges (
        .clk   (clk),
        .we    (ed_we),
        .waddr (EA'(cnt_reg)),
        .wdata (ed_wdata),
        .raddr (ed_raddr),
        .rdata (ed_rdata)
    );

    tss_ram #(.WIDTH(EA), .DEPTH(EDGE_CAP)) u_rev (
        .clk   (clk),
        .we    (rv_we),
        .waddr (EA'(r_reg)),
        .wdata (EA'(e_reg)),
        .raddr (EA'(cur_reg)),
        .rdata (rv_rdata)
    );

    tss_ram #(.WIDTH(NA + EW), .DEPTH(NODE_CAP)) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    tss_ram #(.WIDTH(NA), .DEPTH(NODE_CAP)) u_finish (
        .clk   (clk),
        .we    (fl_we),
        .waddr (NA'(fc_reg)),
        .wdata (top_reg),
        .raddr (NA'(fc_reg - NW'(1))),
        .rdata (fl_rdata)
    );

    tss_ram #(.WIDTH(CW), .DEPTH(NODE_CAP)) u_comp (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (comp_reg),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= NW'(NODE_CAP))
        else $error("walk stack deeper than node count");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg[0] == 1'b0 ||
        state_reg == tss_pkg::S_WR2)
        else $error("edge count odd outside second edge write");
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == tss_pkg::S_EVAL))
        else $error("result strobe without evaluation");
    assert property (@(posedge clk) disable iff (!rst_n) nlim_reg <= NW'(NODE_CAP))
        else $error("node limit beyond capacity");

endmodule

FILE: sv/two_sat_solver.sv
// Top level of the 2-SAT solver: clause front end, queue and solve back end.
// Depends on tss_pkg, tss_front, tss_back and tss_ram.
//
//  Channel   Handshake            Fields
//  --------  -------------------  ---------------------------------------------
//  request   start / busy         first_var first_negated second_var
//                                 second_negated last_clause
//  result    done (one cycle)     satisfiable var_count assignment overflow
//
// A stored clause occupies the back end while its implication edge and its
// contrapositive are written in turn through the edge memory write port. The
// final clause starts the solve: the reverse edges are ordered, then the forward
// and reverse depth-first passes run, then each variable is evaluated. busy stays
// high from the final clause until its result strobe, and while the two-entry
// queue is full; the receiver cannot stall.
// Reset clears all control state; the edge memories need no clearing.
`timescale 1ns / 1ps

module two_sat_solver #(
    parameter int NUM_VARS    = 32,
    parameter int MAX_CLAUSES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tss_pkg::VAR_W-1:0]  first_var,
    input  logic                       first_negated,
    input  logic [tss_pkg::VAR_W-1:0]  second_var,
    input  logic                       second_negated,
    input  logic                       last_clause,
    output logic                       done,
    output logic                       satisfiable,
    output logic [tss_pkg::VCNT_W-1:0] var_count,
    output logic [tss_pkg::ASG_W-1:0]  assignment,
    output logic                       overflow
);

    logic             q_valid;
    logic             q_pop;
    tss_pkg::clause_t q_item;

    tss_front #(.NUM_VARS(NUM_VARS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_var      (first_var),
        .first_negated  (first_negated),
        .second_var     (second_var),
        .second_negated (second_negated),
        .last_clause    (last_clause),
        .done           (done),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    tss_back #(.NUM_VARS(NUM_VARS), .MAX_CLAUSES(MAX_CLAUSES)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .done        (done),
        .satisfiable (satisfiable),
        .var_count   (var_count),
        .assignment  (assignment),
        .overflow    (overflow)
    );

endmodule

FILE: tb/sv/tb_two_sat_solver.sv
// Self-checking testbench for two_sat_solver: sends clause requests and checks
// each solve result against a predictor of the implication graph solve.
// Depends on tss_pkg and the two_sat_solver RTL.
`timescale 1ns / 1ps

module tb_two_sat_solver;

    localparam int EDGE_MAX   = 512;
    localparam int NODE_MAX   = 64;
    localparam int CYCLE_STOP = 10_000_000;

    typedef struct {
        bit                       sat;
        bit [tss_pkg::VCNT_W-1:0] vcnt;
        bit [tss_pkg::ASG_W-1:0]  asg;
        bit                       lost;
    } solve_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [tss_pkg::VAR_W-1:0] first_var = '0;
    logic first_negated = 1'b0;
    logic [tss_pkg::VAR_W-1:0] second_var = '0;
    logic second_negated = 1'b0;
    logic last_clause = 1'b0;
    logic busy;
    logic done;
    logic satisfiable;
    logic [tss_pkg::VCNT_W-1:0] var_count;
    logic [tss_pkg::ASG_W-1:0] assignment;
    logic overflow;

    bit [5:0] edge_from [EDGE_MAX];
    bit [5:0] edge_to [EDGE_MAX];
    int stored_edges = 0;
    int nodes_used = 0;
    bit clause_lost = 1'b0;
    solve_t pending_solves[$];
    int mismatches = 0;
    int cycles = 0;
    bit idle_on = 1'b1;

    two_sat_solver DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_var(first_var), .first_negated(first_negated),
        .second_var(second_var), .second_negated(second_negated),
        .last_clause(last_clause), .done(done), .satisfiable(satisfiable),
        .var_count(var_count), .assignment(assignment), .overflow(overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic solve_t solve_store();
        int n;
        int r;
        int fc;
        int sp;
        int node;
        int e;
        int comp;
        int root;
        int ct;
        int cf;
        int rev_list [EDGE_MAX];
        bit [1:0] mark [NODE_MAX];
        int comp_of [NODE_MAX];
        int fin [NODE_MAX];
        int stk [NODE_MAX];
        int cur [NODE_MAX];
        solve_t res;
        n = (nodes_used > NODE_MAX) ? NODE_MAX : nodes_used;
        r = 0;
        for (int s = 0; s < n; s++)
            for (int k = 0; k < stored_edges; k++)
                if (edge_from[k] == s && r < EDGE_MAX)
                begin
                    rev_list[r] = k;
                    r++;
                end
        for (int k = 0; k < NODE_MAX; k++)
        begin
            mark[k] = 0;
            comp_of[k] = 0;
        end
        fc = 0;
        for (int i = 0; i < n; i++)
        begin
            if (mark[i] != 0)
                continue;
            sp = 1;
            mark[i] = 1;
            stk[0] = i;
            cur[0] = 0;
            while (sp > 0)
            begin
                node = stk[sp-1];
                e = cur[sp-1];
                while (e < stored_edges && !(edge_from[e] == node && edge_to[e] < n
                       && mark[edge_to[e]] == 0))
                    e++;
                if (e < stored_edges && sp < NODE_MAX)
                begin
                    cur[sp-1] = e + 1;
                    mark[edge_to[e]] = 1;
                    stk[sp] = edge_to[e];
                    cur[sp] = 0;
                    sp++;
                end
                else
                begin
                    if (fc < NODE_MAX)
                    begin
                        fin[fc] = node;
                        fc++;
                    end
                    sp--;
                end
            end
        end
        comp = 0;
        for (int k = fc; k > 0; k--)
        begin
            root = fin[k-1];
            if (mark[root] != 1)
                continue;
            sp = 1;
            mark[root] = 2;
            comp_of[root] = comp % 64;
            stk[0] = root;
            cur[0] = 0;
            while (sp > 0)
            begin
                node = stk[sp-1];
                e = cur[sp-1];
                while (e < stored_edges && !(edge_to[rev_list[e]] == node
                       && mark[edge_from[rev_list[e]]] == 1))
                    e++;
                if (e < stored_edges && sp < NODE_MAX)
                begin
                    cur[sp-1] = e + 1;
                    mark[edge_from[rev_list[e]]] = 2;
                    comp_of[edge_from[rev_list[e]]] = comp % 64;
                    stk[sp] = edge_from[rev_list[e]];
                    cur[sp] = 0;
                    sp++;
                end
                else
                    sp--;
            end
            comp++;
        end
        res.sat = 1'b1;
        res.asg = '0;
        for (int x = 0; 2 * x + 1 < n; x++)
        begin
            ct = comp_of[2*x];
            cf = comp_of[2*x+1];
            if (ct == cf)
                res.sat = 1'b0;
            else if (ct > cf && x < 32)
                res.asg[x] = 1'b1;
        end
        if (!res.sat)
            res.asg = '0;
        res.vcnt = tss_pkg::VCNT_W'(n / 2);
        res.lost = clause_lost;
        return res;
    endfunction

    function automatic void apply_clause(bit [4:0] a, bit an, bit [4:0] b, bit bn, bit lst);
        int top;
        if (stored_edges + 2 > EDGE_MAX)
            clause_lost = 1'b1;
        else
        begin
            top = ((a > b) ? a : b) * 2 + 2;
            if (top > nodes_used)
                nodes_used = top;
            edge_from[stored_edges] = 6'(a * 2 + (an ? 0 : 1));
            edge_to[stored_edges] = 6'(b * 2 + (bn ? 1 : 0));
            edge_from[stored_edges+1] = 6'(b * 2 + (bn ? 0 : 1));
            edge_to[stored_edges+1] = 6'(a * 2 + (an ? 1 : 0));
            stored_edges += 2;
        end
        if (lst)
        begin
            pending_solves.push_back(solve_store());
            stored_edges = 0;
            nodes_used = 0;
            clause_lost = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_STOP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        solve_t want;
        if (rst_n && done)
        begin
            if (pending_solves.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_solves.pop_front();
                if (satisfiable !== want.sat)
                    report_mismatch($sformatf("satisfiable %b, want %b", satisfiable, want.sat));
                if (var_count !== want.vcnt)
                    report_mismatch($sformatf("var_count %0d, want %0d", var_count, want.vcnt));
                if (assignment !== want.asg)
                    report_mismatch($sformatf("assignment %h, want %h", assignment, want.asg));
                if (overflow !== want.lost)
                    report_mismatch($sformatf("overflow %b, want %b", overflow, want.lost));
            end
        end
    end

    task automatic send_clause(input int a, input int an, input int b,
                               input int bn, input int lst);
        if (idle_on && $urandom_range(0, 99) < 8)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        first_var <= tss_pkg::VAR_W'(a);
        first_negated <= 1'(an);
        second_var <= tss_pkg::VAR_W'(b);
        second_negated <= 1'(bn);
        last_clause <= 1'(lst);
        @(negedge clk);
        while (busy)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        apply_clause(5'(a), 1'(an), 5'(b), 1'(bn), 1'(lst));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_solves.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_batch(input int len, input int top_var);
        for (int i = 0; i < len; i++)
            send_clause($urandom_range(0, top_var), $urandom_range(0, 1),
                        $urandom_range(0, top_var), $urandom_range(0, 1), i == len - 1);
    endtask

    task automatic test_extremes();
        send_clause(0, 0, 0, 0, 1);
        send_clause(31, 1, 31, 1, 1);
        send_clause(0, 0, 31, 1, 1);
        send_clause(31, 0, 0, 1, 1);
        send_clause(5, 0, 5, 1, 1);
        send_clause(3, 0, 3, 0, 0);
        send_clause(3, 1, 3, 1, 1);
        send_clause(9, 0, 9, 0, 1);
        send_clause(0, 0, 1, 0, 0);
        send_clause(0, 1, 1, 0, 0);
        send_clause(0, 0, 1, 1, 0);
        send_clause(0, 1, 1, 1, 1);
        send_clause(2, 0, 4, 1, 0);
        send_clause(4, 0, 6, 1, 0);
        send_clause(6, 0, 2, 1, 1);
    endtask

    task automatic test_store_full();
        for (int i = 0; i < 258; i++)
            send_clause($urandom_range(0, 3), $urandom_range(0, 1),
                        $urandom_range(0, 3), $urandom_range(0, 1), i == 257);
        for (int i = 0; i < 257; i++)
            send_clause($urandom_range(0, 31), $urandom_range(0, 1),
                        $urandom_range(0, 31), $urandom_range(0, 1), i == 256);
        send_clause(1, 0, 2, 1, 1);
    endtask

    task automatic test_drained_pause();
        random_batch(6, 7);
        wait_drained();
        random_batch(4, 31);
    endtask

    task automatic test_random();
        int sent;
        int batch;
        sent = 0;
        batch = 0;
        while (sent < 310)
        begin
            int len;
            idle_on = !(batch >= 10 && batch < 25);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            random_batch(len, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : 31);
            sent += len;
            batch++;
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_store_full();
        test_drained_pause();
        test_random();
        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/tss_pkg.sv
sv/tss_ram.sv
sv/tss_front.sv
sv/tss_back.sv
sv/two_sat_solver.sv
tb/sv/tb_two_sat_solver.sv
